[rtl/core/scc_pkg.sv]
// shared types, widths and constants of the sphere capsule contact core
package scc_pkg;

  localparam int MUL_MAG = 40;
  localparam int MUL_W   = MUL_MAG + 1;
  localparam int PROD_W  = 2 * MUL_MAG + 1;
  localparam int IT_W    = 128;
  localparam int IT_QW   = 64;
  localparam int IT_CW   = 7;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  typedef enum logic {
    IT_DIV,
    IT_SQRT
  } it_op_t;

  typedef struct packed {
    logic                    go;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             go;
    it_op_t           op;
    logic [IT_W-1:0]  a;
    logic [IT_W-1:0]  b;
    logic [IT_CW-1:0] cnt;
  } it_req_t;

  typedef struct packed {
    logic             done;
    logic [IT_QW-1:0] res;
  } it_rsp_t;

endpackage

[rtl/core/scc_mul.sv]
// sequential signed multiplier, four multiplier bits per cycle
module scc_mul import scc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int DIG = MUL_MAG / 4;
  localparam int CW  = $clog2(DIG + 1);
  localparam int AW  = 2 * MUL_MAG + 4;

  logic [MUL_MAG-1:0]      am;
  logic [MUL_MAG-1:0]      bm;
  logic [AW-1:0]           acc;
  logic [CW-1:0]           cnt;
  logic                    neg;
  logic                    busy;
  logic                    fin;
  logic [MUL_W-1:0]        amag;
  logic [MUL_W-1:0]        bmag;
  logic [MUL_MAG+3:0]      part;
  logic [MUL_MAG+4:0]      sum;
  logic [AW-1:0]           acc_next;
  logic signed [PROD_W-1:0] pm;

  always_comb begin
    amag     = req.a[MUL_W-1] ? MUL_W'(-req.a) : MUL_W'(req.a);
    bmag     = req.b[MUL_W-1] ? MUL_W'(-req.b) : MUL_W'(req.b);
    part     = am * bm[3:0];
    sum      = {1'b0, acc[AW-1:MUL_MAG]} + {1'b0, part};
    acc_next = AW'({sum, acc[MUL_MAG-1:4]});
    pm       = PROD_W'(acc[2*MUL_MAG-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= fin;
      fin      <= !req.go && busy && (cnt == CW'(1));
      if (req.go) begin
        am   <= amag[MUL_MAG-1:0];
        bm   <= bmag[MUL_MAG-1:0];
        acc  <= '0;
        cnt  <= CW'(DIG);
        neg  <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        bm  <= bm >> 4;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
      if (fin) begin
        rsp.prod <= neg ? -pm : pm;
      end
    end
  end

endmodule

[rtl/core/scc_iter.sv]
// shared bit-serial divider and square root unit, one bit per cycle
module scc_iter import scc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  it_req_t req,
  output it_rsp_t rsp
);

  logic [IT_W-1:0]  x;
  logic [IT_W-1:0]  y;
  logic [IT_W-1:0]  bitr;
  logic [IT_QW-1:0] q;
  logic [IT_CW-1:0] cnt;
  it_op_t           op;
  logic             busy;
  logic [IT_W-1:0]  r2;
  logic [IT_W-1:0]  t;
  logic [IT_W-1:0]  opa;
  logic [IT_W-1:0]  opb;
  logic [IT_W:0]    diff;
  logic             ge;
  logic [IT_W-1:0]  x_next;
  logic [IT_W-1:0]  y_next;
  logic [IT_QW-1:0] q_next;

  always_comb begin
    r2     = {x[IT_W-2:0], 1'b0};
    t      = y + bitr;
    opa    = (op == IT_DIV) ? r2 : x;
    opb    = (op == IT_DIV) ? y : t;
    diff   = {1'b0, opa} - {1'b0, opb};
    ge     = !diff[IT_W];
    x_next = ge ? diff[IT_W-1:0] : opa;
    q_next = {q[IT_QW-2:0], ge};
    if (op == IT_DIV) begin
      y_next = y;
    end else begin
      y_next = ge ? (y >> 1) + bitr : y >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.go && busy && (cnt == IT_CW'(1));
      if (req.go) begin
        x    <= req.a;
        y    <= (req.op == IT_DIV) ? req.b : '0;
        bitr <= req.b;
        q    <= '0;
        cnt  <= req.cnt;
        op   <= req.op;
        busy <= 1'b1;
      end else if (busy) begin
        x    <= x_next;
        y    <= y_next;
        bitr <= bitr >> 2;
        q    <= q_next;
        cnt  <= cnt - 1'b1;
        if (cnt == IT_CW'(1)) begin
          busy     <= 1'b0;
          rsp.res  <= (op == IT_DIV) ? q_next : y_next[IT_QW-1:0];
        end
      end
    end
  end

endmodule

[rtl/core/sphere_capsule_contact_core.sv]
// top level of the sphere against capsule contact core
// A request with mode 0 loads the sphere centre and radius; it stays idle
// and gives no result. A request with mode 1 carries a capsule and runs the
// contact test; it gives one result when the shapes touch and none otherwise.
// Requests are taken when in_valid is high and in_stall low; in_stall is high
// while a capsule test runs. The contact margin is written through cfg_wr_en
// and cfg_wr_data; the user must do so only while the core is idle, which the core does not enforce.
// A capsule test holds in_stall until it ends, longer with a contact than
// when the shapes are apart and shorter when the centres coincide. Its length
// is set by up to 25 products on the shared multiplier (four bits a cycle)
// and the shared divider and square root unit (30, 34, 64 and three times
// 32 steps).
// The result sits in an output register until taken with out_valid high and
// out_stall low; a new request is taken meanwhile, and a following test waits
// at its end while out_stall holds the previous result.
// Reset clears the stored sphere, the margin, the state, the start strobes and out_valid.
module sphere_capsule_contact_core import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] rot_w,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  input  logic [30:0]        radius,
  input  logic [30:0]        half_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               touching,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z,
  output logic signed [31:0] separation
);

  localparam int ABW = 36;
  localparam int APW = 36;
  localparam int VW  = 37;

  localparam logic [4:0] MI_WW      = 5'd0;
  localparam logic [4:0] MI_XX      = 5'd1;
  localparam logic [4:0] MI_XY      = 5'd2;
  localparam logic [4:0] MI_WZ      = 5'd3;
  localparam logic [4:0] MI_XZ      = 5'd4;
  localparam logic [4:0] MI_WY      = 5'd5;
  localparam logic [4:0] MI_OFF     = 5'd6;
  localparam logic [4:0] MI_OFF_END = 5'd8;
  localparam logic [4:0] MI_ND      = 5'd9;
  localparam logic [4:0] MI_ND_END  = 5'd14;
  localparam logic [4:0] MI_V       = 5'd15;
  localparam logic [4:0] MI_V_END   = 5'd17;
  localparam logic [4:0] MI_SQ      = 5'd18;
  localparam logic [4:0] MI_SQ_END  = 5'd20;
  localparam logic [4:0] MI_INFL    = 5'd21;
  localparam logic [4:0] MI_PT      = 5'd22;
  localparam logic [4:0] MI_PT_END  = 5'd24;

  localparam logic [2:0] IP_T    = 3'd0;
  localparam logic [2:0] IP_DIST = 3'd1;
  localparam logic [2:0] IP_LEN  = 3'd2;
  localparam logic [2:0] IP_N0   = 3'd3;
  localparam logic [2:0] IP_N2   = 3'd5;

  localparam logic [IT_CW-1:0] T_STEPS    = IT_CW'(30);
  localparam logic [IT_CW-1:0] DIST_STEPS = IT_CW'(34);
  localparam logic [IT_CW-1:0] LEN_STEPS  = IT_CW'(64);
  localparam logic [IT_CW-1:0] N_STEPS    = IT_CW'(32);
  localparam logic [IT_W-1:0]  DIST_BIT   = IT_W'(1) << (2 * DIST_STEPS - 2);
  localparam logic [IT_W-1:0]  LEN_BIT    = IT_W'(1) << (2 * LEN_STEPS - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MWAIT,
    ST_ITER,
    ST_IWAIT,
    ST_OUT
  } st_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  st_t state;
  logic [4:0] idx;
  logic [2:0] iph;
  logic       mul_go;
  logic       it_go;

  logic signed [31:0]       sc [3];
  logic [30:0]              sr;
  logic [30:0]              cd;
  logic signed [31:0]       pv [3];
  logic signed [31:0]       rw;
  logic signed [31:0]       rx;
  logic signed [31:0]       ry;
  logic signed [31:0]       rz;
  logic [30:0]              hh;
  logic [30:0]              cr;
  logic signed [PROD_W-30:0] tmp;
  logic signed [31:0]       ax [3];
  logic signed [ABW-1:0]    ab [3];
  logic signed [APW-1:0]    ap [3];
  logic signed [PROD_W-1:0] nom;
  logic signed [PROD_W-1:0] den;
  logic [30:0]              tq;
  logic signed [VW-1:0]     v [3];
  logic [PROD_W-1:0]        sq;
  logic [IT_QW-1:0]         len;
  logic signed [31:0]       nv [3];
  logic signed [31:0]       pt [3];
  logic signed [31:0]       sep;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  it_req_t  ireq;
  it_rsp_t  irsp;

  logic signed [MUL_W-1:0]  ma;
  logic signed [MUL_W-1:0]  mb;
  logic [1:0]               mlane;
  logic [4:0]               mrel;
  it_op_t                   iop;
  logic [IT_W-1:0]          ia;
  logic [IT_W-1:0]          ib;
  logic [IT_CW-1:0]         icnt;
  logic [1:0]               ilane;
  logic [2:0]               irel;
  logic [VW-1:0]            vmag;
  logic [32:0]              rsum;
  logic [32:0]              infl;
  logic signed [PROD_W-30:0] p29;
  logic signed [PROD_W-31:0] p30;
  logic signed [63:0]       off64;
  logic signed [PROD_W-1:0] den_sum;
  logic [31:0]              qn;
  logic signed [31:0]       qc;

  assign rsum = 33'(sr) + 33'(cr);
  assign infl = rsum + 33'(cd);

  always_comb begin
    ma    = '0;
    mb    = '0;
    mlane = 2'd0;
    mrel  = '0;
    case (idx) inside
      MI_WW: begin ma = MUL_W'(rw); mb = MUL_W'(rw); end
      MI_XX: begin ma = MUL_W'(rx); mb = MUL_W'(rx); end
      MI_XY: begin ma = MUL_W'(rx); mb = MUL_W'(ry); end
      MI_WZ: begin ma = MUL_W'(rw); mb = MUL_W'(rz); end
      MI_XZ: begin ma = MUL_W'(rx); mb = MUL_W'(rz); end
      MI_WY: begin ma = MUL_W'(rw); mb = MUL_W'(ry); end
      [MI_OFF:MI_OFF_END]: begin
        mrel  = idx - MI_OFF;
        mlane = mrel[1:0];
        ma    = MUL_W'(ax[mlane]);
        mb    = MUL_W'(hh);
      end
      [MI_ND:MI_ND_END]: begin
        mrel  = idx - MI_ND;
        mlane = mrel[2:1];
        ma    = idx[0] ? MUL_W'(ap[mlane]) : MUL_W'(ab[mlane]);
        mb    = MUL_W'(ab[mlane]);
      end
      [MI_V:MI_V_END]: begin
        mrel  = idx - MI_V;
        mlane = mrel[1:0];
        ma    = MUL_W'(ab[mlane]);
        mb    = MUL_W'(tq);
      end
      [MI_SQ:MI_SQ_END]: begin
        mrel  = idx - MI_SQ;
        mlane = mrel[1:0];
        ma    = MUL_W'(v[mlane]);
        mb    = MUL_W'(v[mlane]);
      end
      MI_INFL: begin ma = MUL_W'(infl); mb = MUL_W'(infl); end
      [MI_PT:MI_PT_END]: begin
        mrel  = idx - MI_PT;
        mlane = mrel[1:0];
        ma    = MUL_W'(nv[mlane]);
        mb    = MUL_W'(sr);
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    irel  = iph - IP_N0;
    ilane = irel[1:0];
    vmag  = v[ilane][VW-1] ? VW'(-v[ilane]) : VW'(v[ilane]);
    iop   = IT_DIV;
    ia    = '0;
    ib    = '0;
    icnt  = N_STEPS;
    case (iph) inside
      IP_T: begin
        iop  = IT_DIV;
        ia   = IT_W'(nom);
        ib   = IT_W'(den);
        icnt = T_STEPS;
      end
      IP_DIST: begin
        iop  = IT_SQRT;
        ia   = IT_W'(sq);
        ib   = DIST_BIT;
        icnt = DIST_STEPS;
      end
      IP_LEN: begin
        iop  = IT_SQRT;
        ia   = IT_W'(sq) << 60;
        ib   = LEN_BIT;
        icnt = LEN_STEPS;
      end
      default: begin
        iop  = IT_DIV;
        ia   = IT_W'(vmag) << 28;
        ib   = IT_W'(len);
        icnt = N_STEPS;
      end
    endcase
  end

  always_comb begin
    p29     = $signed(mrsp.prod[PROD_W-1:29]);
    p30     = $signed(mrsp.prod[PROD_W-1:30]);
    off64   = 64'(p30);
    den_sum = den + mrsp.prod;
    qn      = irsp.res[31:0];
    qc      = (qn > 32'(Q30_ONE)) ? Q30_ONE : $signed(qn);
  end

  assign mreq = '{go: mul_go, a: ma, b: mb};
  assign ireq = '{go: it_go, op: iop, a: ia, b: ib, cnt: icnt};

  scc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  scc_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (ireq),
    .rsp (irsp)
  );

  assign in_stall = rst || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_go    <= 1'b0;
      it_go     <= 1'b0;
      out_valid <= 1'b0;
      cd        <= '0;
      sr        <= '0;
      sc[0]     <= '0;
      sc[1]     <= '0;
      sc[2]     <= '0;
    end else begin
      mul_go <= (state == ST_MUL);
      it_go  <= (state == ST_ITER);
      if (cfg_wr_en) begin
        cd <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!mode) begin
              sc[0] <= pos_x;
              sc[1] <= pos_y;
              sc[2] <= pos_z;
              sr    <= radius;
            end else begin
              pv[0] <= pos_x;
              pv[1] <= pos_y;
              pv[2] <= pos_z;
              rw    <= rot_w;
              rx    <= rot_x;
              ry    <= rot_y;
              rz    <= rot_z;
              hh    <= half_height;
              cr    <= radius;
              nom   <= '0;
              den   <= '0;
              sq    <= '0;
              idx   <= MI_WW;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mrsp.done) begin
            idx <= idx + 1'b1;
            case (idx) inside
              MI_WW, MI_XY, MI_XZ: begin
                tmp   <= p29;
                state <= ST_MUL;
              end
              MI_XX: begin
                ax[0] <= sat32(64'(tmp) + 64'(p29) - 64'(Q30_ONE));
                state <= ST_MUL;
              end
              MI_WZ: begin
                ax[1] <= sat32(64'(tmp) + 64'(p29));
                state <= ST_MUL;
              end
              MI_WY: begin
                ax[2] <= sat32(64'(tmp) - 64'(p29));
                state <= ST_MUL;
              end
              [MI_OFF:MI_OFF_END]: begin
                ab[mlane] <= ABW'(-(off64 <<< 1));
                ap[mlane] <= APW'(64'(sc[mlane]) - 64'(pv[mlane]) - off64);
                state     <= ST_MUL;
              end
              [MI_ND:MI_ND_END]: begin
                if (idx[0]) begin
                  nom <= nom + mrsp.prod;
                end else begin
                  den <= den_sum;
                end
                if (idx == MI_ND_END) begin
                  if (den_sum != '0 && !nom[PROD_W-1] && nom != '0) begin
                    if (nom >= den_sum) begin
                      tq    <= 31'(Q30_ONE);
                      state <= ST_MUL;
                    end else begin
                      iph   <= IP_T;
                      state <= ST_ITER;
                    end
                  end else begin
                    tq    <= '0;
                    state <= ST_MUL;
                  end
                end else begin
                  state <= ST_MUL;
                end
              end
              [MI_V:MI_V_END]: begin
                v[mlane] <= VW'(64'(ap[mlane]) - 64'(p30));
                state    <= ST_MUL;
              end
              [MI_SQ:MI_SQ_END]: begin
                sq    <= sq + $unsigned(mrsp.prod);
                state <= ST_MUL;
              end
              MI_INFL: begin
                if (sq >= $unsigned(mrsp.prod)) begin
                  state <= ST_IDLE;
                end else begin
                  iph   <= IP_DIST;
                  state <= ST_ITER;
                end
              end
              [MI_PT:MI_PT_END]: begin
                pt[mlane] <= sat32(64'(sc[mlane]) - 64'(p30));
                if (idx == MI_PT_END) begin
                  state <= ST_OUT;
                end else begin
                  state <= ST_MUL;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_ITER: begin
          state <= ST_IWAIT;
        end
        ST_IWAIT: begin
          if (irsp.done) begin
            case (iph) inside
              IP_T: begin
                tq    <= 31'(irsp.res[29:0]);
                idx   <= MI_V;
                state <= ST_MUL;
              end
              IP_DIST: begin
                sep <= sat32($signed(64'(irsp.res) - 64'(rsum)));
                if (sq == '0) begin
                  nv[0] <= Q30_ONE;
                  nv[1] <= '0;
                  nv[2] <= '0;
                  idx   <= MI_PT;
                  state <= ST_MUL;
                end else begin
                  iph   <= IP_LEN;
                  state <= ST_ITER;
                end
              end
              IP_LEN: begin
                len   <= irsp.res;
                iph   <= IP_N0;
                state <= ST_ITER;
              end
              default: begin
                nv[ilane] <= v[ilane][VW-1] ? -qc : qc;
                if (iph == IP_N2) begin
                  idx   <= MI_PT;
                  state <= ST_MUL;
                end else begin
                  iph   <= iph + 1'b1;
                  state <= ST_ITER;
                end
              end
            endcase
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            touching   <= 1'b1;
            point_x    <= pt[0];
            point_y    <= pt[1];
            point_z    <= pt[2];
            normal_x   <= nv[0];
            normal_y   <= nv[1];
            normal_z   <= nv[2];
            separation <= sep;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/scc_checker.sv]
// port level checks of the sphere capsule contact core and their bind
module scc_checker import scc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic               touching,
  input logic signed [31:0] normal_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_touch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> touching)
    else $error("result without contact flag");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode |=> in_stall)
    else $error("capsule request did not make the core busy");

  a_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a test in progress");

  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x <= Q30_ONE) && (normal_x >= -Q30_ONE))
    else $error("normal out of unit range");

endmodule

bind sphere_capsule_contact_core scc_checker u_scc_checker (.*);
